[rtl/sha256_stream_hash_macros.svh]
// Assertion macros used by the hasher RTL.
`ifndef SHA256_STREAM_HASH_MACROS_SVH
`define SHA256_STREAM_HASH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SHS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/shs_pkg.sv]
// Shared types, constants and round functions of the stream hasher.
`default_nettype none

package shs_pkg;

   typedef logic [31:0] word_type;

   // Eight chaining or working words, element 0 is word a / H0.
   typedef logic [0:7][31:0] hash_type;

   // Control from the sequencer to the block buffer.
   typedef struct packed {
      logic       shift_byte;
      logic       expand;
      logic [7:0] fill_byte;
   } sched_ctrl_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_START   = 56;

   localparam hash_type INITIAL_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int unsigned s);
      return (x >> s) | (x << (32 - s));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // Round constants, one per round.
   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/sha256_stream_hash.sv]
// Byte-stream hasher: one byte per request, 8-word digest out.
// A data byte is taken while idle; each 64th byte then runs 64 rounds + add-back, stalling requests.
// A last request pads one byte per cycle to the block end, then compresses; an extra
// block (no room for the length) pads 64 more bytes and compresses again. Then 8 words,
// one per cycle while rsp_stall is low. The single shared round unit limits throughput.
// Synchronous reset loads the initial hash and clears all counters; no clearing pass.
`default_nettype none
`include "sha256_stream_hash_macros.svh"

module sha256_stream_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_data,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      AFT_IDLE,
      AFT_PAD,
      AFT_OUT
   } after_type;

   state_type         state_ff, state_in;
   after_type         after_ff, after_in;
   logic [5:0]        count_ff, count_in;
   logic [63:0]       bitlen_ff, bitlen_in;
   logic [5:0]        round_ff, round_in;
   logic              sent80_ff, sent80_in;
   logic              final_ff, final_in;
   logic [2:0]        idx_ff, idx_in;
   shs_pkg::hash_type hash_ff, hash_in;
   shs_pkg::hash_type work_ff, work_in;

   shs_pkg::hash_type      work_next;
   shs_pkg::word_type      sched_word;
   shs_pkg::sched_ctrl_type sched_ctrl;
   logic [7:0]             pad_byte;
   logic                   req_take;
   logic                   rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign rsp_digest_word = hash_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   shs_round u_round (
      .work_cur   (work_ff),
      .sched_word (sched_word),
      .round_idx  (round_ff),
      .work_next  (work_next)
   );

   shs_sched u_sched (
      .clock      (clock),
      .ctrl       (sched_ctrl),
      .sched_word (sched_word)
   );

   // padding stream: 0x80, zeros, then big-endian bit length in the final block
   always_comb begin
      if (!sent80_ff) begin
         pad_byte = shs_pkg::PAD_BYTE;
      end else if (final_ff && (count_ff >= 6'(shs_pkg::LEN_START))) begin
         pad_byte = bitlen_ff[{~count_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      after_in   = after_ff;
      count_in   = count_ff;
      bitlen_in  = bitlen_ff;
      round_in   = round_ff;
      sent80_in  = sent80_ff;
      final_in   = final_ff;
      idx_in     = idx_ff;
      hash_in    = hash_ff;
      work_in    = work_ff;
      sched_ctrl = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sent80_in = 1'b0;
               final_in  = 1'b0;
               if (req_has_data) begin
                  sched_ctrl.shift_byte = 1'b1;
                  sched_ctrl.fill_byte  = req_data_byte;
                  count_in  = count_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
                  if (count_ff == 6'(shs_pkg::BLOCK_BYTES - 1)) begin
                     work_in  = hash_ff;
                     round_in = '0;
                     state_in = ST_COMP;
                     after_in = req_last_byte ? AFT_PAD : AFT_IDLE;
                  end else if (req_last_byte) begin
                     state_in = ST_PAD;
                  end
               end else if (req_last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.fill_byte  = pad_byte;
            count_in = count_ff + 6'd1;
            if (!sent80_ff) begin
               sent80_in = 1'b1;
               // length fits behind the pad byte only below the length field
               final_in  = (count_ff < 6'(shs_pkg::LEN_START));
            end
            if (count_ff == 6'(shs_pkg::BLOCK_BYTES - 1)) begin
               final_in = 1'b1;
               work_in  = hash_ff;
               round_in = '0;
               state_in = ST_COMP;
               after_in = final_ff ? AFT_OUT : AFT_PAD;
            end
         end
         ST_COMP: begin
            sched_ctrl.expand = 1'b1;
            work_in  = work_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(shs_pkg::BLOCK_BYTES - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            idx_in = '0;
            unique case (after_ff)
               AFT_PAD: state_in = ST_PAD;
               AFT_OUT: state_in = ST_OUT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (rsp_take) begin
               // rotate so the next word sits at the output
               hash_in = {hash_ff[1:7], hash_ff[0]};
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in   = shs_pkg::INITIAL_HASH;
                  count_in  = '0;
                  bitlen_in = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         after_ff  <= AFT_IDLE;
         count_ff  <= '0;
         bitlen_ff <= '0;
         round_ff  <= '0;
         sent80_ff <= 1'b0;
         final_ff  <= 1'b0;
         idx_ff    <= '0;
         hash_ff   <= shs_pkg::INITIAL_HASH;
      end else begin
         state_ff  <= state_in;
         after_ff  <= after_in;
         count_ff  <= count_in;
         bitlen_ff <= bitlen_in;
         round_ff  <= round_in;
         sent80_ff <= sent80_in;
         final_ff  <= final_in;
         idx_ff    <= idx_in;
         hash_ff   <= hash_in;
      end
      work_ff <= work_in;
   end

   // checks
   `SHS_ASSERT_IMP(a_no_req_during_rsp, rsp_valid, req_stall, "request taken while digest out")
   `SHS_ASSERT_NXT(a_ready_after_digest, rsp_take && rsp_last_word,
      !req_stall && !rsp_valid, "not ready after final digest word")
   `SHS_ASSERT_NXT(a_comp_ends, (state_ff == ST_COMP) && (round_ff == 6'd63),
      state_ff == ST_FIN, "compression ran past 64 rounds")
   `SHS_ASSERT_IMP(a_digest_starts_at_zero, $rose(rsp_valid), rsp_word_index == 3'd0,
      "digest does not start at word 0")

endmodule

`default_nettype wire

[rtl/shs_round.sv]
// One compression round, the arithmetic unit reused for all 64 rounds.
`default_nettype none

module shs_round (
   input  wire shs_pkg::hash_type work_cur,
   input  wire shs_pkg::word_type sched_word,
   input  wire logic [5:0]        round_idx,
   output shs_pkg::hash_type      work_next
);

   shs_pkg::word_type t1;
   shs_pkg::word_type t2;
   shs_pkg::word_type ch;
   shs_pkg::word_type maj;

   // choose / majority on e,f,g and a,b,c
   always_comb begin
      ch  = (work_cur[4] & work_cur[5]) ^ (~work_cur[4] & work_cur[6]);
      maj = (work_cur[0] & work_cur[1]) ^ (work_cur[0] & work_cur[2]) ^
            (work_cur[1] & work_cur[2]);
      t1  = work_cur[7] + shs_pkg::big_sigma1(work_cur[4]) + ch +
            shs_pkg::round_k(round_idx) + sched_word;
      t2  = shs_pkg::big_sigma0(work_cur[0]) + maj;
   end

   // shift the working words down one place
   assign work_next = {t1 + t2, work_cur[0], work_cur[1], work_cur[2],
                       work_cur[3] + t1, work_cur[4], work_cur[5], work_cur[6]};

endmodule

`default_nettype wire

[rtl/shs_sched.sv]
// Block buffer: bytes shift in, then it rolls as the message schedule.
`default_nettype none

module shs_sched (
   input  wire logic                    clock,
   input  wire shs_pkg::sched_ctrl_type ctrl,
   output shs_pkg::word_type            sched_word
);

   // 16 words, word 0 in the top bits
   logic [511:0]      blk_ff;
   logic [511:0]      blk_in;
   shs_pkg::word_type w0;
   shs_pkg::word_type w1;
   shs_pkg::word_type w9;
   shs_pkg::word_type w14;
   shs_pkg::word_type w_new;

   assign w0  = blk_ff[511:480];
   assign w1  = blk_ff[479:448];
   assign w9  = blk_ff[223:192];
   assign w14 = blk_ff[63:32];

   // W[t+16] from the window W[t..t+15]
   assign w_new = shs_pkg::small_sigma1(w14) + w9 + shs_pkg::small_sigma0(w1) + w0;

   assign sched_word = w0;

   always_comb begin
      blk_in = blk_ff;
      if (ctrl.shift_byte) begin
         blk_in = {blk_ff[503:0], ctrl.fill_byte};
      end else if (ctrl.expand) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

`default_nettype wire
